// File: rtl/sha1_pkg.sv
// Package with SHA-1 constants, command and status types.
package sha1_pkg;
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [1:0] {
    BSEL_DATA = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } bsel_e;

  typedef struct packed {
    logic  wr_byte;      // write one byte into the buffer at the fill position
    bsel_e bsel;         // byte source
    logic  count_bit;    // advance the bit count by eight
    logic  round_start;  // load working words from chaining words
    logic  round_step;   // run one round
    logic  round_fold;   // add working words into chaining words
    logic  reset_state;  // back to initial chaining words and zero length
  } sha1_cmd_t;

  typedef struct packed {
    logic [5:0] pos;     // next buffer byte position
    logic       last_round;
  } sha1_sts_t;
endpackage

// File: rtl/sha1_stream_hash.sv
// Top level of the SHA-1 stream hash: controller plus datapath.
// A byte beat is written into the buffer; the byte that fills a block then runs
// 80 rounds on one shared round unit and one fold before the next byte is taken.
// A finish beat pads one byte a cycle while no compression runs, and runs one or two
// compressions, then offers the five digest beats, one per cycle when the sink is ready.
// Reset loads the initial chaining words and zero length; the buffer is not cleared.
module sha1_stream_hash import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  // Controller and datapath talk through one command and one status struct.
  sha1_cmd_t cmd;
  sha1_sts_t sts;

  sha1_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
    .out_valid_o, .out_ready_i, .word_index_o, .last_word_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  sha1_dpath u_dpath (
    .clk_i, .rst_ni, .data_byte_i, .cmd_i(cmd), .word_index_i(word_index_o),
    .sts_o(sts), .digest_word_o
  );
endmodule

// File: rtl/sha1_ctrl.sv
// Controller state machine for the SHA-1 stream hash.
module sha1_ctrl import sha1_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] word_index_o,
  output logic       last_word_o,
  output sha1_cmd_t  cmd_o,
  input  sha1_sts_t  sts_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_FOLD, S_PADZ, S_LEN, S_EMIT
  } state_e;

  state_e state_q;
  logic   finishing_q;
  logic [2:0] idx_q;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_EMIT);
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 3'd4);

  always_comb begin
    cmd_o = '0;
    cmd_o.bsel = BSEL_DATA;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.wr_byte = 1'b1;
          cmd_o.bsel = kind_i ? BSEL_PAD : BSEL_DATA;
          cmd_o.count_bit = ~kind_i;
          cmd_o.round_start = (sts_i.pos == 6'd63);
        end
      end
      S_ROUND: cmd_o.round_step = 1'b1;
      S_FOLD:  cmd_o.round_fold = 1'b1;
      S_PADZ: begin
        cmd_o.wr_byte = 1'b1;
        cmd_o.bsel = BSEL_ZERO;
        cmd_o.round_start = (sts_i.pos == 6'd63);
      end
      S_LEN: begin
        cmd_o.wr_byte = 1'b1;
        cmd_o.bsel = BSEL_LEN;
        cmd_o.round_start = (sts_i.pos == 6'd63);
      end
      S_EMIT: cmd_o.reset_state = out_ready_i && (idx_q == 3'd4);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      finishing_q <= 1'b0;
      idx_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            finishing_q <= kind_i;
            if (sts_i.pos == 6'd63) state_q <= S_ROUND;
            else if (kind_i) state_q <= (sts_i.pos == 6'd55) ? S_LEN : S_PADZ;
          end
        end
        S_ROUND: if (sts_i.last_round) state_q <= S_FOLD;
        S_FOLD: begin
          if (!finishing_q) state_q <= S_IDLE;
          else if (sts_i.pos == 6'd0 && idx_q == 3'd1) begin
            state_q <= S_EMIT;
            idx_q <= '0;
          end else begin
            state_q <= S_PADZ;
          end
        end
        S_PADZ: begin
          if (sts_i.pos == 6'd63) state_q <= S_ROUND;
          else if (sts_i.pos == 6'd55) state_q <= S_LEN;
        end
        S_LEN: begin
          if (sts_i.pos == 6'd63) begin
            state_q <= S_ROUND;
            idx_q <= 3'd1;  // marks the length block as the final block
          end
        end
        S_EMIT: begin
          if (out_ready_i) begin
            if (idx_q == 3'd4) begin
              state_q <= S_IDLE;
              finishing_q <= 1'b0;
              idx_q <= '0;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> finishing_q) else $error("emit outside finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q <= 3'd4) else $error("word index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> !in_ready_o) else $error("ready during rounds");
endmodule

// File: rtl/sha1_dpath.sv
// Datapath: block buffer, message schedule, round unit and chaining words.
module sha1_dpath import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  sha1_cmd_t   cmd_i,
  input  logic [2:0]  word_index_i,
  output sha1_sts_t   sts_o,
  output logic [31:0] digest_word_o
);
  logic [63:0] len_q;
  logic [5:0]  pos_q;
  logic [31:0] h_q [5];
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [6:0]  rnd_q;
  logic [7:0]  byte_d;
  logic [31:0] f, k, t, wn;
  logic [2:0]  li;

  assign li = 3'd7 - pos_q[2:0];
  always_comb begin
    case (cmd_i.bsel)
      BSEL_DATA: byte_d = data_byte_i;
      BSEL_PAD:  byte_d = PAD_BYTE;
      BSEL_ZERO: byte_d = 8'h00;
      BSEL_LEN:  byte_d = len_q[{li, 3'b000} +: 8];
      default:   byte_d = 8'h00;
    endcase
  end

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q; k = K3;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    wn = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  end

  assign sts_o.pos = pos_q;
  assign sts_o.last_round = (rnd_q == 7'd79);
  assign digest_word_o = h_q[word_index_i];

  // Bytes are packed big-endian straight into the sixteen schedule words, which
  // double as the block buffer; the rounds then shift them in place.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) w_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= byte_d;
    if (cmd_i.round_start) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end else if (cmd_i.round_step) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= {wn[30:0], wn[31]};
      e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]}; b_q <= a_q; a_q <= t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; pos_q <= '0; rnd_q <= '0;
      h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
      h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
    end else begin
      if (cmd_i.wr_byte) pos_q <= pos_q + 6'd1;
      if (cmd_i.count_bit) len_q <= len_q + 64'd8;
      if (cmd_i.round_start) rnd_q <= '0;
      else if (cmd_i.round_step) rnd_q <= rnd_q + 7'd1;
      if (cmd_i.round_fold) begin
        h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
      end
      if (cmd_i.reset_state) begin
        len_q <= '0; pos_q <= '0;
        h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
        h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round_step |-> rnd_q <= 7'd79) else $error("round counter overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round_fold |-> $past(rnd_q) == 7'd79) else $error("fold before last round");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reset_state |-> !cmd_i.wr_byte) else $error("write during reset");
endmodule
